>>> hw/rtl/first_fit_heap_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Concurrent check macros shared by the allocator RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during reset.
`define FFHA_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ffha: same-cycle check failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define FFHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ffha: next-cycle check failed");
`else
`define FFHA_ASSERT_SAME(label, ante, cons)
`define FFHA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Command and result word types, operation codes and fixed field widths.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int ADDR_W = 10;
	localparam int SIZE_W = 14;
	localparam int CFG_W  = 11;

	localparam logic [CFG_W-1:0]  CFG_RESET      = 11'd1024;
	localparam int                MIN_POOL_WORDS = 4;
	localparam logic [SIZE_W-1:0] BIG_MAX        = 14'h3FFF;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_NOFIT = 1'b1;

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_ALLOC   = 2'd1,
		OP_FREE    = 2'd2,
		OP_BIGGEST = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [SIZE_W-1:0] size_bytes;
		logic [ADDR_W-1:0] address;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] address_out;
		logic              status;
		logic [SIZE_W-1:0] biggest_bytes;
	} result_t;

endpackage

>>> hw/rtl/first_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator core
// Word pool of signed block headers in one synchronous memory, walked by a
// sequencer that merges adjacent free blocks, allocates first-fit and frees.
// ----------------------------------------------------------------------------
// Usage. A command word is taken on cmd when start is high and busy is low.
// Exactly one result word follows on result, valid for the single cycle in
// which done is high; the receiver must take it then, since nothing holds it.
// The pool size register is written through cfg_valid/cfg_data (cfg_ready is
// always high) and should only be changed while the core is idle.
// Steps per command: init writes the first header and the terminator;
// free reads the header and, if it is allocated, writes it back as free;
// allocate rounds the size to words, then walks the chain, reading each
// header, merging the free blocks that follow a free one and testing the
// merged block for a fit, with a split write when the remainder allows it;
// biggest walks the whole chain the same way without allocating.
// The chain walk sets the rate: each header read has an issue state and
// an evaluate state on the memory's one read port, and free blocks between
// allocated ones add a merge probe and a fit test. The byte-to-word rounding
// is a multiplication by a constant reciprocal, registered in S_NEED.
// A walk that leaves the pool without meeting a terminator ends in S_HREAD.
// Reset clears the sequencer and loads the pool size register with 1024. The
// header memory is not cleared; its contents mean nothing until an init.
// Only one command is in flight, so memory writes never race a read.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_core_defines.svh"

module first_fit_heap_allocator_core #(
	parameter int POOL_WORDS = 1024,
	parameter int WORD_BYTES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  ffha_pkg::cmd_t             cmd,
	output logic                       done,
	output ffha_pkg::result_t          result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [ffha_pkg::CFG_W-1:0] cfg_data
);

	import ffha_pkg::*;

	// Memory index width, pointer/count width (holds POOL_WORDS itself) and
	// the signed header width.
	localparam int AW  = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
	localparam int CW  = $clog2(POOL_WORDS + 1);
	localparam int CW1 = CW + 1;
	localparam int HW  = CW + 1;
	// Widths for size compares, init/free arithmetic and the byte product.
	localparam int CMW = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
	localparam int XW  = ((CW > CFG_W) ? CW : CFG_W) + 1;
	localparam int BPW = ((CW + 5 > SIZE_W) ? CW + 5 : SIZE_W) + 1;
	// Rounding to words: the rounded-up byte count times a reciprocal of the
	// word size. Four extra shift bits keep it exact for word sizes up to 16.
	localparam int RND_W  = SIZE_W + 1;
	localparam int RCP_SH = RND_W + 4;
	localparam int RCP_W  = RCP_SH + 1;
	localparam int PRD_W  = RND_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP_MUL =
		RCP_W'(((1 << RCP_SH) + WORD_BYTES - 1) / WORD_BYTES);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT0,
		S_INIT1,
		S_NEED,
		S_HREAD,
		S_HEVAL,
		S_MREAD,
		S_MEVAL,
		S_FIT,
		S_SPLIT,
		S_FREE_RD,
		S_FREE_EV
	} state_t;

	// Next header position, saturated at POOL_WORDS so that it reads as the
	// end of the pool.
	function automatic logic [CW-1:0] step_ptr(input logic [CW-1:0] base,
		input logic [CW-1:0] mag);
		logic [CW1-1:0] sum;
		sum = CW1'(base) + CW1'(mag) + CW1'(1);
		return (sum >= CW1'(POOL_WORDS)) ? CW'(POOL_WORDS) : CW'(sum);
	endfunction

	state_t              state_q;
	op_t                 op_q;
	logic [CFG_W-1:0]    cfg_q;
	logic                done_q;
	result_t             result_q;

	// Walk registers: current header position, merge probe position, merged
	// payload of the block under test, outer step count and best free size.
	logic [CW-1:0]       hp_q;
	logic [CW-1:0]       qp_q;
	logic [CW-1:0]       cur_q;
	logic [CW-1:0]       steps_q;
	logic [CW-1:0]       best_q;
	logic                free_ok_q;

	// Requested byte count and the rounded word count.
	logic [SIZE_W-1:0]   num_q;
	logic [SIZE_W-1:0]   need_q;

	// Header memory and its port.
	logic signed [HW-1:0] hdr_mem [POOL_WORDS];
	logic signed [HW-1:0] hdr_rd_s1;
	logic                 mem_we;
	logic [AW-1:0]        mem_wa;
	logic signed [HW-1:0] mem_wd;
	logic                 mem_re;
	logic [AW-1:0]        mem_ra;

	logic                 accept;
	logic                 is_alloc;
	logic [XW-1:0]        cfg_x;
	logic [XW-1:0]        n_words;
	logic [XW-1:0]        addr_x;
	logic                 free_ok;
	logic [CW-1:0]        free_idx;
	logic [CW-1:0]        h_mag;
	logic [CW-1:0]        merged;
	logic                 fit;
	logic [CMW-1:0]       left;
	logic                 split;
	logic [AW-1:0]        split_idx;
	logic [BPW-1:0]       big_prod;
	logic [SIZE_W-1:0]    big_sat;
	logic [ADDR_W-1:0]    addr_out;
	logic [RND_W-1:0]     num_rnd;
	logic [PRD_W-1:0]     need_prod;
	logic [SIZE_W-1:0]    need_raw;
	result_t              walk_end_res;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;
	assign cfg_ready = 1'b1;
	assign is_alloc  = (op_q == OP_ALLOC);

	// The init layout uses the register clamped to the legal pool range.
	assign cfg_x   = XW'(cfg_q);
	assign n_words = (cfg_x < XW'(MIN_POOL_WORDS)) ? XW'(MIN_POOL_WORDS) :
		((cfg_x > XW'(POOL_WORDS)) ? XW'(POOL_WORDS) : cfg_x);

	// A free names a payload address; its header sits one word below. Address
	// zero has no header and anything past the pool is ignored.
	assign addr_x   = XW'(cmd.address);
	assign free_ok  = (cmd.address != '0) && ((addr_x - XW'(1)) < XW'(POOL_WORDS));
	assign free_idx = CW'(addr_x - XW'(1));

	assign h_mag  = hdr_rd_s1[HW-1] ? CW'(-hdr_rd_s1) : CW'(hdr_rd_s1);
	assign merged = CW'(CW1'(cur_q) + CW1'(h_mag) + CW1'(1));

	// First fit on the merged block. A remainder is split off only when it
	// can carry its own header plus at least one payload word.
	assign fit       = is_alloc && (CMW'(cur_q) >= CMW'(need_q));
	assign left      = CMW'(cur_q) - CMW'(need_q);
	assign split     = (left >= CMW'(2));
	assign split_idx = AW'(CW1'(hp_q) + CW1'(need_q) + CW1'(1));
	assign addr_out  = ADDR_W'(CW1'(hp_q) + CW1'(1));

	// Largest free payload in bytes, saturating at the field's top value.
	assign big_prod = BPW'(best_q) * BPW'(WORD_BYTES);
	assign big_sat  = (big_prod > BPW'(BIG_MAX)) ? BIG_MAX : SIZE_W'(big_prod);

	assign walk_end_res = is_alloc ?
		'{address_out: '0, status: STATUS_NOFIT, biggest_bytes: '0} :
		'{address_out: '0, status: STATUS_OK, biggest_bytes: big_sat};

	// Bytes to whole words, rounding up.
	assign num_rnd   = RND_W'(num_q) + RND_W'(WORD_BYTES - 1);
	assign need_prod = PRD_W'(num_rnd) * PRD_W'(RCP_MUL);
	assign need_raw  = SIZE_W'(need_prod >> RCP_SH);

	// Memory port control.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = '0;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = '0;
		case (state_q)
			S_INIT0: begin
				mem_we = 1'b1;
				mem_wa = '0;
				mem_wd = HW'(n_words - XW'(2));
			end
			S_INIT1: begin
				mem_we = 1'b1;
				mem_wa = AW'(n_words - XW'(1));
				mem_wd = '0;
			end
			S_HREAD, S_FREE_RD: begin
				mem_re = 1'b1;
				mem_ra = AW'(hp_q);
			end
			S_MREAD: begin
				mem_re = 1'b1;
				mem_ra = AW'(qp_q);
			end
			S_FIT: begin
				mem_we = 1'b1;
				mem_wa = AW'(hp_q);
				if (!fit) begin
					mem_wd = HW'(cur_q);
				end else if (split) begin
					mem_wd = HW'(0) - HW'(need_q);
				end else begin
					mem_wd = HW'(0) - HW'(cur_q);
				end
			end
			S_SPLIT: begin
				mem_we = 1'b1;
				mem_wa = split_idx;
				mem_wd = HW'(left - CMW'(1));
			end
			S_FREE_EV: begin
				mem_we = free_ok_q && hdr_rd_s1[HW-1];
				mem_wa = AW'(hp_q);
				mem_wd = HW'(0) - hdr_rd_s1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hdr_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			hdr_rd_s1 <= hdr_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= OP_INIT;
			cfg_q     <= CFG_RESET;
			done_q    <= 1'b0;
			result_q  <= '0;
			hp_q      <= '0;
			qp_q      <= '0;
			cur_q     <= '0;
			steps_q   <= '0;
			best_q    <= '0;
			free_ok_q <= 1'b0;
			num_q     <= '0;
			need_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= cmd.op;
						case (cmd.op)
							OP_INIT: begin
								state_q <= S_INIT0;
							end
							OP_ALLOC: begin
								num_q   <= cmd.size_bytes;
								state_q <= S_NEED;
							end
							OP_FREE: begin
								hp_q      <= free_idx;
								free_ok_q <= free_ok;
								state_q   <= S_FREE_RD;
							end
							OP_BIGGEST: begin
								hp_q    <= '0;
								steps_q <= '0;
								best_q  <= '0;
								state_q <= S_HREAD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_INIT0: begin
					state_q <= S_INIT1;
				end
				S_INIT1: begin
					done_q   <= 1'b1;
					result_q <= '{address_out: '0, status: STATUS_OK, biggest_bytes: '0};
					state_q  <= S_IDLE;
				end
				S_NEED: begin
					// A zero-byte request still takes one word, since a zero
					// header would end the chain.
					need_q  <= (need_raw == '0) ? SIZE_W'(1) : need_raw;
					hp_q    <= '0;
					steps_q <= '0;
					best_q  <= '0;
					state_q <= S_HREAD;
				end
				S_HREAD: begin
					if ((hp_q >= CW'(POOL_WORDS)) || (steps_q >= CW'(POOL_WORDS))) begin
						done_q   <= 1'b1;
						result_q <= walk_end_res;
						state_q  <= S_IDLE;
					end else begin
						steps_q <= steps_q + CW'(1);
						state_q <= S_HEVAL;
					end
				end
				S_HEVAL: begin
					if (hdr_rd_s1 == '0) begin
						done_q   <= 1'b1;
						result_q <= walk_end_res;
						state_q  <= S_IDLE;
					end else if (hdr_rd_s1[HW-1]) begin
						hp_q    <= step_ptr(hp_q, h_mag);
						state_q <= S_HREAD;
					end else begin
						cur_q   <= h_mag;
						qp_q    <= step_ptr(hp_q, h_mag);
						state_q <= S_MREAD;
					end
				end
				S_MREAD: begin
					if (qp_q >= CW'(POOL_WORDS)) begin
						state_q <= S_FIT;
					end else begin
						state_q <= S_MEVAL;
					end
				end
				S_MEVAL: begin
					// Absorb a directly following free block, header included.
					if (!hdr_rd_s1[HW-1] && (hdr_rd_s1 != '0)) begin
						cur_q   <= merged;
						qp_q    <= step_ptr(qp_q, h_mag);
						state_q <= S_MREAD;
					end else begin
						state_q <= S_FIT;
					end
				end
				S_FIT: begin
					if (cur_q > best_q) begin
						best_q <= cur_q;
					end
					if (fit) begin
						if (split) begin
							state_q <= S_SPLIT;
						end else begin
							done_q   <= 1'b1;
							result_q <= '{address_out: addr_out, status: STATUS_OK,
								biggest_bytes: '0};
							state_q  <= S_IDLE;
						end
					end else begin
						hp_q    <= step_ptr(hp_q, cur_q);
						state_q <= S_HREAD;
					end
				end
				S_SPLIT: begin
					done_q   <= 1'b1;
					result_q <= '{address_out: addr_out, status: STATUS_OK,
						biggest_bytes: '0};
					state_q  <= S_IDLE;
				end
				S_FREE_RD: begin
					state_q <= S_FREE_EV;
				end
				S_FREE_EV: begin
					done_q   <= 1'b1;
					result_q <= '{address_out: '0, status: STATUS_OK, biggest_bytes: '0};
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A result word is only shown once the sequencer is back to idle.
	`FFHA_ASSERT_SAME(a_done_idle, done, !busy)
	// Results never come back to back: every command passes through a busy state first.
	`FFHA_ASSERT_NEXT(a_done_single, done, !done)
	// An accepted command always occupies the sequencer on the next cycle.
	`FFHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	// Only an allocation can report that nothing fits.
	`FFHA_ASSERT_SAME(a_nofit_alloc, done && result.status == STATUS_NOFIT, op_q == OP_ALLOC)
	// A nonzero address only comes from a successful allocation.
	`FFHA_ASSERT_SAME(a_addr_alloc, done && result.address_out != '0, op_q == OP_ALLOC && result.status == STATUS_OK)

endmodule
